### hw/rtl/fmss_pkg.sv
// Shared widths and term-count codes for the fixed-point multiply, sum and shift core.
package fmss_pkg;

  localparam int unsigned WordBits  = 32;
  localparam int unsigned ProdBits  = 2 * WordBits;
  localparam int unsigned ShiftBits = 6;
  localparam int unsigned OpBits    = 2;

  // Term-count codes. The code with both bits set behaves like three terms.
  localparam logic [OpBits-1:0] TermsOne   = 2'd0;
  localparam logic [OpBits-1:0] TermsTwo   = 2'd1;
  localparam logic [OpBits-1:0] TermsThree = 2'd2;

endpackage

### hw/rtl/fixed_point_mul_sum_shift_core.sv
// Top level of the fixed-point multiply, sum and shift core.
//
// Usage: a request on the input channel (in_valid_i / in_ready_o) carries a term
// count op_i, three pairs of signed 32-bit factors and a shift amount. The core
// forms the 64-bit signed products a*b, c*d and e*f, adds the first one, two or
// three of them (as op_i selects) modulo 2^64, shifts the sum arithmetically
// right by shift_amount_i and returns the low 32 bits on the output channel
// (out_valid_o / out_ready_i, payload result_o).
// An accepted request moves through the stage 1, 2 and 3 registers into the
// output register, where out_valid_o rises; while the receiver keeps taking
// results, one request is accepted in every cycle. The four register stages are
// the three parallel multipliers, the first 64-bit add, the second 64-bit add
// and the barrel shifter feeding the output register.
// Each stage has its own valid bit and is loaded whenever it is empty or the
// stage after it moves, so bubbles are squeezed out and a new request is taken
// while a finished result still waits. When the receiver stalls, the output
// register holds its result and the stages behind it fill up before in_ready_o
// falls; nothing is dropped or repeated.
// Reset clears all valid bits; the core then holds no request and starts
// accepting in the first cycle after reset is released.
module fixed_point_mul_sum_shift_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [fmss_pkg::OpBits-1:0]    op_i,
  input  logic signed [fmss_pkg::WordBits-1:0]  op_a_i,
  input  logic signed [fmss_pkg::WordBits-1:0]  op_b_i,
  input  logic signed [fmss_pkg::WordBits-1:0]  op_c_i,
  input  logic signed [fmss_pkg::WordBits-1:0]  op_d_i,
  input  logic signed [fmss_pkg::WordBits-1:0]  op_e_i,
  input  logic signed [fmss_pkg::WordBits-1:0]  op_f_i,
  input  logic        [fmss_pkg::ShiftBits-1:0] shift_amount_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fmss_pkg::WordBits-1:0]  result_o
);
  import fmss_pkg::*;

  // Stage valid bits.
  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  // A stage may load when it is empty or its content moves on.
  logic rdy1, rdy2, rdy3, rdy4;

  // Full signed products of the three factor pairs.
  logic signed [ProdBits-1:0]  prod_ab, prod_cd, prod_ef;
  // Stage 1: products, already zeroed for terms that are not selected.
  logic signed [ProdBits-1:0]  p0_d, p1_d, p2_d;
  logic signed [ProdBits-1:0]  p0_q, p1_q, p2_q;
  logic        [ShiftBits-1:0] sh1_q;
  // Stage 2: sum of the first two products.
  logic signed [ProdBits-1:0]  sum01_d, sum01_q, p2b_q;
  logic        [ShiftBits-1:0] sh2_q;
  // Stage 3: full sum.
  logic signed [ProdBits-1:0]  sum_d, sum_q;
  logic        [ShiftBits-1:0] sh3_q;
  // Stage 4: shifted result.
  logic signed [ProdBits-1:0]  shifted;
  logic signed [WordBits-1:0]  result_d, result_q;

  logic use_second, use_third;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign v1_d = rdy1 ? in_valid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  // The second product is used for every code but one term, the third
  // whenever the upper code bit is set (three terms and the unused code).
  assign use_second = (op_i != TermsOne);
  assign use_third  = op_i[1];

  // Each is a 32 by 32 signed product; the operands are sign-extended so the
  // full 64-bit result is kept.
  assign prod_ab = ProdBits'(op_a_i) * ProdBits'(op_b_i);
  assign prod_cd = ProdBits'(op_c_i) * ProdBits'(op_d_i);
  assign prod_ef = ProdBits'(op_e_i) * ProdBits'(op_f_i);

  always_comb begin
    p0_d = prod_ab;
    p1_d = use_second ? prod_cd : '0;
    p2_d = use_third  ? prod_ef : '0;
  end

  assign sum01_d  = p0_q + p1_q;
  assign sum_d    = sum01_q + p2b_q;
  assign shifted  = sum_q >>> sh3_q;
  assign result_d = shifted[WordBits-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p0_q  <= p0_d;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      sh1_q <= shift_amount_i;
    end
    if (rdy2 && v1_q) begin
      sum01_q <= sum01_d;
      p2b_q   <= p2_q;
      sh2_q   <= sh1_q;
    end
    if (rdy3 && v2_q) begin
      sum_q <= sum_d;
      sh3_q <= sh2_q;
    end
    if (rdy4 && v3_q) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = v4_q;
  assign result_o    = result_q;

endmodule

### hw/rtl/fmss_checker.sv
// Port-level checker for the fixed-point multiply, sum and shift core, with its bind.
module fmss_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_ready_o,
  input logic signed [fmss_pkg::WordBits-1:0]  op_b_i,
  input logic signed [fmss_pkg::WordBits-1:0]  op_d_i,
  input logic signed [fmss_pkg::WordBits-1:0]  op_f_i,
  input logic                                  out_valid_o,
  input logic                                  out_ready_i,
  input logic signed [fmss_pkg::WordBits-1:0]  result_o
);
  import fmss_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(result_o))
    else $error("result changed while stalled");

  // With the receiver ready, the input side can never be blocked.
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked although receiver is ready");

  // A request whose products are all zero comes out as zero from the output
  // register when the receiver keeps taking results.
  a_zero_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && op_b_i == '0 && op_d_i == '0 && op_f_i == '0)
      ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o && result_o == '0)
    else $error("zero-product request not delivered in four cycles");

endmodule

bind fixed_point_mul_sum_shift_core fmss_checker u_fmss_checker (.*);
